// ----- hdl/dsm_pkg.sv -----
// ----------------------------------------------------------------------------
// dsm_pkg: shared types and codes for the dual stack shared memory
// Request and result structs, operation and status codes, cell control.
// ----------------------------------------------------------------------------
package dsm_pkg;

    // default number of words in the shared store
    localparam int DEPTH_DEF = 16;

    // word width of one stack entry
    localparam int WORD_W = 32;

    // operation codes
    localparam logic [2:0] OP_PUSH_L = 3'd0;
    localparam logic [2:0] OP_POP_L  = 3'd1;
    localparam logic [2:0] OP_SHOW_L = 3'd2;
    localparam logic [2:0] OP_PUSH_R = 3'd3;
    localparam logic [2:0] OP_POP_R  = 3'd4;
    localparam logic [2:0] OP_SHOW_R = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef logic signed [WORD_W-1:0] word_t;

    // one request
    typedef struct packed {
        logic [2:0] op;
        word_t      push_value;
    } dsm_cmd_t;

    // one result
    typedef struct packed {
        logic [1:0] status;
        logic       has_value;
        word_t      element;
        logic       last;
    } dsm_res_t;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic load;   // copy stored word into the readout chain
        logic shift;  // advance the readout chain by one place
        logic up;     // 1: chain moves towards the last entry, 0: towards entry 0
    } cell_ctrl_t;

endpackage

// ----- hdl/dual_stack_shared_memory.sv -----
// ----------------------------------------------------------------------------
// dual_stack_shared_memory: two stacks in one store of DEPTH words
// Left stack grows up from entry 0, right stack grows down from the last one.
// ----------------------------------------------------------------------------
// Usage
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one request: push, pop
//   or show on the left or right stack. cmd_stall is high while a readout is
//   in progress, so one request is handled at a time.
//   res channel (res_valid / res_stall / res) streams the chosen stack after
//   the operation: left from entry 0 upwards, right from the last entry
//   inwards, every result carrying the operation's status, last set on the
//   final one. An empty stack gives one marker result with has_value low.
//   The first result is valid the cycle after the request is taken.
//   Results stream at one a cycle while res_stall is low, then the next request is
//   taken the cycle after the last result goes. The readout chain in the row of
//   cells moves one place towards the output per result.
//   Unused op codes are taken with no result and no change.
//   res_stall holds the chain and the result steady until it is taken.
//   Reset clears both stack counts; store contents stay undefined and are
//   never read before they are written.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory #(
    parameter int DEPTH = dsm_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  dsm_pkg::dsm_cmd_t cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output dsm_pkg::dsm_res_t res
);
    import dsm_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IDXW = $clog2(DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic          state_reg, state_next;
    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] right_reg, right_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [1:0]    status_reg, status_next;
    logic          side_reg, side_next;

    logic            accept;
    logic            op_known;
    logic            is_right;
    logic            push_ok;
    logic [1:0]      status_c;
    logic [CW:0]     fill_sum;
    logic [IDXW-1:0] wr_addr;
    logic [CW-1:0]   count_c;
    logic            take;
    cell_ctrl_t      ctrl;
    word_t           chain [DEPTH];

    // handshake
    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = (state_reg == S_READ);
    assign take      = res_valid && !res_stall;

    assign fill_sum = {1'b0, left_reg} + {1'b0, right_reg};

    // decode the request and work out new counts
    always_comb
    begin
        op_known   = 1'b1;
        is_right   = 1'b0;
        push_ok    = 1'b0;
        status_c   = ST_OK;
        left_next  = left_reg;
        right_next = right_reg;
        wr_addr    = left_reg[IDXW-1:0];
        case (cmd.op)
            OP_PUSH_L:
            begin
                if (fill_sum >= (CW + 1)'(DEPTH))
                begin
                    status_c = ST_OVERFLOW;
                end
                else
                begin
                    push_ok   = 1'b1;
                    left_next = left_reg + CW'(1);
                end
            end
            OP_POP_L:
            begin
                if (left_reg == '0)
                begin
                    status_c = ST_UNDERFLOW;
                end
                else
                begin
                    left_next = left_reg - CW'(1);
                end
            end
            OP_SHOW_L:
            begin
                status_c = ST_OK;
            end
            OP_PUSH_R:
            begin
                is_right = 1'b1;
                wr_addr  = IDXW'(DEPTH - 1) - right_reg[IDXW-1:0];
                if (fill_sum >= (CW + 1)'(DEPTH))
                begin
                    status_c = ST_OVERFLOW;
                end
                else
                begin
                    push_ok    = 1'b1;
                    right_next = right_reg + CW'(1);
                end
            end
            OP_POP_R:
            begin
                is_right = 1'b1;
                if (right_reg == '0)
                begin
                    status_c = ST_UNDERFLOW;
                end
                else
                begin
                    right_next = right_reg - CW'(1);
                end
            end
            OP_SHOW_R:
            begin
                is_right = 1'b1;
            end
            default:
            begin
                op_known = 1'b0;
            end
        endcase
        count_c = is_right ? right_next : left_next;
    end

    // control sequencer
    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        status_next = status_reg;
        side_next   = side_reg;
        if (accept && op_known)
        begin
            state_next  = S_READ;
            rem_next    = count_c;
            status_next = status_c;
            side_next   = is_right;
        end
        else if (take)
        begin
            if (rem_reg <= CW'(1))
            begin
                state_next = S_IDLE;
                rem_next   = '0;
            end
            else
            begin
                rem_next = rem_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            left_reg   <= '0;
            right_reg  <= '0;
            rem_reg    <= '0;
            status_reg <= ST_OK;
            side_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rem_reg    <= rem_next;
            status_reg <= status_next;
            side_reg   <= side_next;
            if (accept && op_known)
            begin
                left_reg  <= left_next;
                right_reg <= right_next;
            end
        end
    end

    // row control
    assign ctrl.load  = accept && op_known;
    assign ctrl.shift = take;
    assign ctrl.up    = side_reg;

    // row of storage cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t lower_w;
        word_t upper_w;

        if (i == 0)
        begin : g_first
            assign lower_w = '0;
        end
        else
        begin : g_mid_lo
            assign lower_w = chain[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_final
            assign upper_w = '0;
        end
        else
        begin : g_mid_hi
            assign upper_w = chain[i+1];
        end

        dsm_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .wr_en      (accept && push_ok && (wr_addr == IDXW'(i))),
            .wr_data    (cmd.push_value),
            .from_lower (lower_w),
            .from_upper (upper_w),
            .chain      (chain[i])
        );
    end

    // result payload from the output end of the chain
    assign res.status    = status_reg;
    assign res.has_value = (rem_reg != '0);
    assign res.last      = (rem_reg <= CW'(1));
    assign res.element   = (rem_reg == '0) ? '0 :
                           (side_reg ? chain[DEPTH-1] : chain[0]);

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_sum <= (CW + 1)'(DEPTH))
        else $error("stack counts exceed store depth");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && res.last) |=> !res_valid)
        else $error("readout continues after last result");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.has_value) |-> res.last)
        else $error("empty marker not flagged last");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> cmd_stall)
        else $error("request taken during readout");

endmodule

// ----- hdl/dsm_cell.sv -----
// ----------------------------------------------------------------------------
// dsm_cell: one entry of the shared store
// Holds one stored word plus one place of the readout shift chain.
// ----------------------------------------------------------------------------
module dsm_cell (
    input  logic                clk,
    input  dsm_pkg::cell_ctrl_t ctrl,
    input  logic                wr_en,
    input  dsm_pkg::word_t      wr_data,
    input  dsm_pkg::word_t      from_lower,
    input  dsm_pkg::word_t      from_upper,
    output dsm_pkg::word_t      chain
);
    import dsm_pkg::*;

    word_t store_reg;
    word_t chain_reg;

    // stored word, written by a push aimed at this entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg <= wr_data;
        end
    end

    // readout chain place: load takes the word as it stands after a push
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            chain_reg <= wr_en ? wr_data : store_reg;
        end
        else if (ctrl.shift)
        begin
            chain_reg <= ctrl.up ? from_lower : from_upper;
        end
    end

    assign chain = chain_reg;

endmodule

// ----- sim/dual_stack_shared_memory_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_tb: self-checking bench for the two-stack store
// Sends push, pop and show requests in random bursts while the result side
// stalls at random. A private copy of both stacks predicts each readout, and
// every result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory_tb;
    import dsm_pkg::*;

    localparam int STORE_DEPTH    = DEPTH_DEF;
    localparam int IDLE_LIMIT     = 2000;
    localparam int HOLDOFF_CYCLES = 80;

    // op codes with no meaning to the block
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam word_t WORD_MIN  = 32'h8000_0000;
    localparam word_t WORD_MAX  = 32'h7fff_ffff;
    localparam word_t WORD_ZERO = 32'h0000_0000;
    localparam word_t WORD_ONES = 32'hffff_ffff;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    dsm_cmd_t cmd       = '0;
    logic     res_valid;
    logic     res_stall = 1'b0;
    dsm_res_t res;

    // shadow of the shared store and both stack heights
    word_t       shadow_store [STORE_DEPTH];
    int unsigned left_depth  = 0;
    int unsigned right_depth = 0;
    dsm_res_t    readout_q [$];

    int errors        = 0;
    int stall_pct     = 0;
    int burst_left    = 0;
    bit sender_idle   = 1'b1;
    bit holdoff_start = 1'b0;
    bit filling       = 1'b1;

    dual_stack_shared_memory #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // apply one request to the shadow stacks and queue the readout it causes
    function automatic void predict_readout(dsm_cmd_t req);
        logic [1:0]  st;
        bit          on_right;
        int unsigned n;
        dsm_res_t    r;
        st = ST_OK;
        case (req.op)
            OP_PUSH_L, OP_PUSH_R:
            begin
                if (left_depth + right_depth >= STORE_DEPTH)
                    st = ST_OVERFLOW;
                else if (req.op == OP_PUSH_L)
                begin
                    shadow_store[left_depth] = req.push_value;
                    left_depth++;
                end
                else
                begin
                    right_depth++;
                    shadow_store[STORE_DEPTH - right_depth] = req.push_value;
                end
            end
            OP_POP_L:
            begin
                if (left_depth == 0)
                    st = ST_UNDERFLOW;
                else
                    left_depth--;
            end
            OP_POP_R:
            begin
                if (right_depth == 0)
                    st = ST_UNDERFLOW;
                else
                    right_depth--;
            end
            OP_SHOW_L, OP_SHOW_R:
                ;
            default:
                return;
        endcase
        on_right = (req.op >= OP_PUSH_R);
        n = on_right ? right_depth : left_depth;
        r.status = st;
        // empty stack gives a lone marker
        if (n == 0)
        begin
            r.has_value = 1'b0;
            r.element   = WORD_ZERO;
            r.last      = 1'b1;
            readout_q.push_back(r);
        end
        else
        begin
            for (int unsigned i = 0; i < n; i++)
            begin
                r.has_value = 1'b1;
                r.element   = shadow_store[on_right ? STORE_DEPTH - 1 - i : i];
                r.last      = (i + 1 == n);
                readout_q.push_back(r);
            end
        end
    endfunction

    // take requests into the shadow, compare each result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        dsm_res_t want;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                predict_readout(cmd);
            if (res_valid && !res_stall)
            begin
                if (readout_q.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d has_value %0b element %0d last %0b",
                             $time, res.status, res.has_value, res.element, res.last);
                    errors++;
                end
                else
                begin
                    want = readout_q.pop_front();
                    if (res.status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, res.status);
                        errors++;
                    end
                    if (res.has_value !== want.has_value)
                    begin
                        $display("%0t: has_value expected %0b got %0b",
                                 $time, want.has_value, res.has_value);
                        errors++;
                    end
                    if (res.element !== want.element)
                    begin
                        $display("%0t: element expected %0d got %0d",
                                 $time, want.element, res.element);
                        errors++;
                    end
                    if (res.last !== want.last)
                    begin
                        $display("%0t: last expected %0b got %0b",
                                 $time, want.last, res.last);
                        errors++;
                    end
                end
            end
        end
    end

    // result side back-pressure, with an occasional long hold-off
    initial
    begin : result_backpressure
        int holdoff_left;
        holdoff_left = 0;
        forever
        begin
            @(posedge clk);
            if (holdoff_start)
            begin
                holdoff_start = 1'b0;
                holdoff_left  = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                res_stall <= 1'b1;
                holdoff_left--;
            end
            else
                res_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // give up when nothing moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // word with the extremes well represented
    function automatic word_t random_word();
        case ($urandom_range(0, 9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return WORD_ZERO;
            3: return WORD_ONES;
            default: return word_t'($urandom);
        endcase
    endfunction

    // op choice leaning towards filling or draining the store
    function automatic logic [2:0] pick_op();
        int unsigned roll;
        bit          side_r;
        roll   = $urandom_range(0, 99);
        side_r = 1'($urandom_range(0, 1));
        if (roll < 4)
            return $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        if (roll < 20)
            return side_r ? OP_SHOW_R : OP_SHOW_L;
        if ((roll < 80) == filling)
            return side_r ? OP_PUSH_R : OP_PUSH_L;
        return side_r ? OP_POP_R : OP_POP_L;
    endfunction

    // offer one request until taken, then maybe pause before the next burst
    task automatic send_request(input logic [2:0] op, input word_t value);
        dsm_cmd_t req;
        req.op         = op;
        req.push_value = value;
        cmd_valid <= 1'b1;
        cmd       <= req;
        do
            @(posedge clk);
        while (cmd_stall);
        if (sender_idle)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 8);
                cmd_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // stop sending until every expected result is in
    task automatic wait_for_drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (readout_q.size() != 0)
            @(posedge clk);
    endtask

    // random requests; spare ops do not count
    task automatic run_random(input int count);
        int         sent;
        logic [2:0] op;
        sent = 0;
        while (sent < count)
        begin
            op = pick_op();
            send_request(op, random_word());
            if (op != OP_SPARE_A && op != OP_SPARE_B)
                sent++;
            if (left_depth + right_depth == STORE_DEPTH)
                filling = 1'b0;
            else if (left_depth + right_depth == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 49) == 0)
                filling = !filling;
        end
    endtask

    // show and pop on empty stacks give the marker
    task automatic test_empty_stacks();
        stall_pct   = 30;
        sender_idle = 1'b1;
        send_request(OP_SHOW_L, random_word());
        send_request(OP_SHOW_R, random_word());
        send_request(OP_POP_L, random_word());
        send_request(OP_POP_R, random_word());
    endtask

    // spare op codes are swallowed with no result
    task automatic test_spare_ops();
        send_request(OP_SPARE_A, WORD_ONES);
        send_request(OP_SPARE_B, WORD_MIN);
    endtask

    // extreme words on both stacks
    task automatic test_extreme_words();
        send_request(OP_PUSH_L, WORD_MIN);
        send_request(OP_PUSH_R, WORD_MAX);
        send_request(OP_PUSH_L, WORD_ZERO);
        send_request(OP_PUSH_R, WORD_ONES);
        send_request(OP_PUSH_L, WORD_MAX);
        send_request(OP_PUSH_R, WORD_MIN);
        send_request(OP_PUSH_L, WORD_ONES);
        send_request(OP_PUSH_R, WORD_ZERO);
    endtask

    // fill the store and push past it on each side
    task automatic test_overflow();
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (left_depth + right_depth < STORE_DEPTH)
                send_request((i % 2) ? OP_PUSH_R : OP_PUSH_L, random_word());
        end
        send_request(OP_PUSH_L, random_word());
        send_request(OP_PUSH_R, random_word());
        filling = 1'b0;
    endtask

    // mixed traffic with and without idling on either side
    task automatic test_random_traffic();
        stall_pct   = 0;
        sender_idle = 1'b0;
        run_random(40);
        stall_pct   = 40;
        sender_idle = 1'b1;
        run_random(40);
        stall_pct   = 15;
        run_random(40);
    endtask

    // long result hold-off while requests keep coming, then heavy stalling
    task automatic test_backpressure();
        wait_for_drain();
        stall_pct     = 0;
        sender_idle   = 1'b0;
        holdoff_start = 1'b1;
        run_random(12);
        wait_for_drain();
        stall_pct = 75;
        run_random(20);
    endtask

    initial
    begin : run_tests
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_stacks();
        test_spare_ops();
        test_extreme_words();
        test_overflow();
        test_random_traffic();
        test_backpressure();
        wait_for_drain();
        repeat (STORE_DEPTH + 4) @(posedge clk);
        if (errors == 0 && readout_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
